// ===== rtl/core/wpat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wpat_pkg;

    // field widths
    localparam int OFF_W = 16;
    localparam int LEN_W = 17;
    localparam int POS_W = 17;
    localparam int MAX_RES = 3;
    localparam int CNT_W = 2;

    // saturation limit default, capped by the offset range
    localparam longint unsigned MAX_TEXT_BYTES_DEF = 64'd65536;
    localparam longint unsigned OFF_RANGE = 64'd65536;

    // bundle queue size
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;

    // stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    // all results caused by one accepted byte
    typedef struct packed {
        logic [CNT_W-1:0]              count;
        logic                          last;
        logic                          ovf;
        logic [MAX_RES-1:0][OFF_W-1:0] off;
        logic [MAX_RES-1:0][LEN_W-1:0] len;
    } wpat_bundle_t;

    typedef struct packed {
        logic empty;
        logic full;
    } wpat_fifo_stat_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             open;
        logic             pend;
    } wpat_front_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpat_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpat_front #(
    parameter longint unsigned MAX_TEXT_BYTES = wpat_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [7:0]                text_byte,
    input  wire logic                      is_last,
    output logic                           push,
    output wpat_pkg::wpat_bundle_t         bundle,
    output wpat_pkg::wpat_front_stat_t     stat
);

    localparam logic [wpat_pkg::POS_W-1:0] LIMIT =
        (MAX_TEXT_BYTES > wpat_pkg::OFF_RANGE) ? wpat_pkg::POS_W'(wpat_pkg::OFF_RANGE)
                                               : wpat_pkg::POS_W'(MAX_TEXT_BYTES);
    localparam logic [wpat_pkg::POS_W-1:0] LIMIT_M1 = LIMIT - 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STOP  = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_APOS  = 8'h27;

    function automatic logic [wpat_pkg::LEN_W-1:0] tok_len(
        input logic [wpat_pkg::POS_W-1:0] e,
        input logic [wpat_pkg::OFF_W-1:0] b
    );
        logic [wpat_pkg::POS_W-1:0] bx;
        bx = {1'b0, b};
        tok_len = (e > bx) ? (e - bx) : wpat_pkg::LEN_W'(1);
    endfunction

    logic [wpat_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       open_reg, open_next;
    logic [wpat_pkg::OFF_W-1:0] begin_reg, begin_next;
    logic                       pend_reg, pend_next;
    logic                       ovf_reg, ovf_next;

    logic                       b_space, b_punct, b_apos, b_word;
    logic [wpat_pkg::OFF_W-1:0] off_cur;
    logic [wpat_pkg::POS_W-1:0] aoff, aend, pos_inc;
    logic                       ovf_now;
    logic [wpat_pkg::CNT_W-1:0] cnt;

    // byte classes
    always_comb
    begin
        b_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                  (text_byte == CH_LF)    || (text_byte == CH_CR);
        b_punct = (text_byte == CH_STOP)  || (text_byte == CH_COMMA) ||
                  (text_byte == CH_EXCL)  || (text_byte == CH_QUEST) ||
                  (text_byte == CH_SEMI)  || (text_byte == CH_COLON);
        b_apos  = (text_byte == CH_APOS);
        b_word  = !b_space && !b_punct && !b_apos;
    end

    // token step for one byte, results in order
    always_comb
    begin
        cnt        = '0;
        bundle     = '0;
        open_next  = open_reg;
        begin_next = begin_reg;
        pend_next  = 1'b0;
        off_cur    = (pos_reg < LIMIT) ? pos_reg[wpat_pkg::OFF_W-1:0]
                                       : LIMIT_M1[wpat_pkg::OFF_W-1:0];
        aoff       = (pos_reg != '0) ? (pos_reg - 1'b1) : '0;
        aend       = ovf_reg ? LIMIT : aoff;
        ovf_now    = ovf_reg || (pos_reg >= LIMIT);
        pos_inc    = (pos_reg < LIMIT) ? (pos_reg + 1'b1) : LIMIT;

        // held apostrophe, the new byte is its right neighbour
        if (pend_reg)
        begin
            if (open_next && !b_word)
            begin
                bundle.off[cnt] = begin_next;
                bundle.len[cnt] = tok_len(aend, begin_next);
                cnt = cnt + 1'b1;
                open_next = 1'b0;
                bundle.off[cnt] = aoff[wpat_pkg::OFF_W-1:0];
                bundle.len[cnt] = wpat_pkg::LEN_W'(1);
                cnt = cnt + 1'b1;
            end
            else if (!open_next && b_word)
            begin
                begin_next = aoff[wpat_pkg::OFF_W-1:0];
                open_next  = 1'b1;
            end
            else if (!open_next)
            begin
                bundle.off[cnt] = aoff[wpat_pkg::OFF_W-1:0];
                bundle.len[cnt] = wpat_pkg::LEN_W'(1);
                cnt = cnt + 1'b1;
            end
        end

        // the new byte; a final apostrophe acts as punctuation
        if (b_space || b_punct || (b_apos && is_last))
        begin
            if (open_next)
            begin
                bundle.off[cnt] = begin_next;
                bundle.len[cnt] = tok_len(pos_reg, begin_next);
                cnt = cnt + 1'b1;
                open_next = 1'b0;
            end
            if (!b_space)
            begin
                bundle.off[cnt] = off_cur;
                bundle.len[cnt] = wpat_pkg::LEN_W'(1);
                cnt = cnt + 1'b1;
            end
        end
        else if (b_apos)
        begin
            pend_next = 1'b1;
        end
        else if (!open_next)
        begin
            begin_next = off_cur;
            open_next  = 1'b1;
        end

        pos_next = pos_inc;
        ovf_next = ovf_now;

        // end of text closes the token and returns to reset state
        if (is_last)
        begin
            if (open_next)
            begin
                bundle.off[cnt] = begin_next;
                bundle.len[cnt] = tok_len(pos_inc, begin_next);
                cnt = cnt + 1'b1;
            end
            open_next  = 1'b0;
            begin_next = '0;
            pend_next  = 1'b0;
            pos_next   = '0;
            ovf_next   = 1'b0;
        end

        bundle.count = cnt;
        bundle.last  = is_last;
        bundle.ovf   = ovf_now;
        push         = accept && (cnt != '0);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            open_reg  <= 1'b0;
            begin_reg <= '0;
            pend_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            begin_reg <= begin_next;
            pend_reg  <= pend_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign stat.pos  = pos_reg;
    assign stat.open = open_reg;
    assign stat.pend = pend_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wpat_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpat_fifo (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire wpat_pkg::wpat_bundle_t    push_data,
    input  wire logic                      pop,
    output wpat_pkg::wpat_bundle_t         head,
    output wpat_pkg::wpat_fifo_stat_t      stat
);

    wpat_pkg::wpat_bundle_t            mem_reg [wpat_pkg::FIFO_DEPTH];
    logic [wpat_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [wpat_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [wpat_pkg::FIFO_AW:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    // pointer and fill count
    always_comb
    begin
        do_push     = push && (count_reg != wpat_pkg::FIFO_DEPTH[wpat_pkg::FIFO_AW:0]);
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = do_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // bundle storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == wpat_pkg::FIFO_DEPTH[wpat_pkg::FIFO_AW:0]);

endmodule

`default_nettype wire

// ===== rtl/core/wpat_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wpat_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wpat_pkg::wpat_bundle_t          head,
    input  wire wpat_pkg::wpat_fifo_stat_t       fifo_stat,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [wpat_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    output logic [wpat_pkg::M_USER_W-1:0]        m_tuser
);

    logic [wpat_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic [wpat_pkg::OFF_W-1:0]  off_reg;
    logic [wpat_pkg::LEN_W-1:0]  len_reg;
    logic                        run_reg, done_reg, ovf_reg;
    logic                        load, final_res;

    // next result of the head bundle into the output register
    always_comb
    begin
        load       = !fifo_stat.empty && (!valid_reg || m_tready);
        final_res  = (idx_reg == (head.count - 1'b1));
        pop        = load && final_res;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = final_res ? '0 : (idx_reg + 1'b1);
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            off_reg  <= head.off[idx_reg];
            len_reg  <= head.len[idx_reg];
            run_reg  <= final_res;
            done_reg <= final_res && head.last;
            ovf_reg  <= head.ovf;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(wpat_pkg::M_DATA_W - wpat_pkg::OFF_W - wpat_pkg::LEN_W){1'b0}},
                       len_reg, off_reg};
    assign m_tlast  = run_reg;
    assign m_tuser  = {ovf_reg, done_reg};

endmodule

`default_nettype wire

// ===== rtl/core/word_punct_apostrophe_tokeniser.sv =====
// channel   dir  transfer                                  fields, lowest bit up
// s_axis    in   one text byte                             tdata: text_byte; tlast: is_last
// m_axis    out  one token                                 tdata: token_offset, token_length;
//                                                          tlast: last_of_run;
//                                                          tuser: text_done, overflow
//
// one text byte is taken every cycle while the bundle queue has room
// each byte yields zero to three tokens, sent from the output register one per ready cycle
// the back end sends a byte's tokens in turn; the four-bundle queue absorbs bursts
// rst_n clears all token state at once; no clearing pass
// a stalled output keeps taking bytes until the queue fills
`timescale 1ns / 1ps
`default_nettype none

module word_punct_apostrophe_tokeniser #(
    parameter longint unsigned MAX_TEXT_BYTES = wpat_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [wpat_pkg::S_DATA_W-1:0]    s_tdata,   // text_byte
    input  wire logic                             s_tlast,   // is_last
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wpat_pkg::M_DATA_W-1:0]         m_tdata,   // token_offset, token_length, pad
    output logic                                  m_tlast,   // last_of_run
    output logic [wpat_pkg::M_USER_W-1:0]         m_tuser    // text_done, overflow
);

    wpat_pkg::wpat_bundle_t      bundle, head;
    wpat_pkg::wpat_fifo_stat_t   fifo_stat;
    wpat_pkg::wpat_front_stat_t  front_stat;
    logic                        accept, push, pop;

    // input transfer
    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;

    wpat_front #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (s_tdata),
        .is_last   (s_tlast),
        .push      (push),
        .bundle    (bundle),
        .stat      (front_stat)
    );

    wpat_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    wpat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // end of text returns the front end to its reset state
    a_text_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=>
        (front_stat.pos == '0 && !front_stat.open && !front_stat.pend))
        else $error("token state not cleared after final byte");

    // text_done only on the final token of a run
    a_done_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("text_done without last_of_run");

    // a token never has zero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:16] != '0))
        else $error("zero token length");

    // a full queue with no pop does not lose its bundles
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_stat.full && !pop) |=> !fifo_stat.empty)
        else $error("queue lost a bundle");

endmodule

`default_nettype wire

// ===== sim/word_punct_apostrophe_tokeniser_test.sv =====
`timescale 1ns / 1ps

module word_punct_apostrophe_tokeniser_test;

    // byte codes that steer the tokeniser
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_APOS  = 8'h27;

    // saturation point of the offsets, as the block is built here
    localparam int unsigned TEXT_LIMIT =
        (wpat_pkg::MAX_TEXT_BYTES_DEF > wpat_pkg::OFF_RANGE) ?
        int'(wpat_pkg::OFF_RANGE) : int'(wpat_pkg::MAX_TEXT_BYTES_DEF);

    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic                          ovf;
        logic                          done;
        logic                          run_end;
        logic [wpat_pkg::LEN_W-1:0]    len;
        logic [wpat_pkg::OFF_W-1:0]    off;
    } token_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [wpat_pkg::S_DATA_W-1:0] s_tdata;   // text_byte
    logic                          s_tlast;   // is_last
    logic                          m_tvalid;
    logic                          m_tready;
    logic [wpat_pkg::M_DATA_W-1:0] m_tdata;   // token_offset, token_length, pad
    logic                          m_tlast;   // last_of_run
    logic [wpat_pkg::M_USER_W-1:0] m_tuser;   // text_done, overflow

    logic steady = 1'b0;

    // byte classes
    function automatic logic is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic is_mark(logic [7:0] b);
        return b == CH_DOT || b == CH_COMMA || b == CH_BANG || b == CH_QUERY ||
               b == CH_SEMI || b == CH_COLON;
    endfunction

    function automatic logic is_body_byte(logic [7:0] b);
        return !is_blank(b) && !is_mark(b) && b != CH_APOS;
    endfunction

    // token predictor and store of awaited tokens
    class token_book;
        int unsigned pos;
        logic        in_token;
        int unsigned tok_start;
        logic        held_apos;
        logic        saturated;
        int unsigned run_off [3];
        int unsigned run_len [3];
        int          run_n;
        token_t      awaited [$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pos       = 0;
            in_token  = 1'b0;
            tok_start = 0;
            held_apos = 1'b0;
            saturated = 1'b0;
        endfunction

        function void add_token(int unsigned off, int unsigned len);
            if (run_n < 3)
            begin
                run_off[run_n] = off;
                run_len[run_n] = len;
                run_n++;
            end
        endfunction

        function void end_token(int unsigned stop);
            if (in_token)
            begin
                add_token(tok_start, stop > tok_start ? stop - tok_start : 1);
                in_token = 1'b0;
            end
        endfunction

        // a held apostrophe, decided by its neighbours
        function void resolve_apos(int unsigned off, int unsigned stop, logic right_word);
            if (in_token && right_word)
                return;
            if (in_token)
            begin
                end_token(stop);
                add_token(off, 1);
            end
            else if (right_word)
            begin
                tok_start = off;
                in_token  = 1'b1;
            end
            else
                add_token(off, 1);
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned p;
            int unsigned off_cur;
            int unsigned aoff;
            int unsigned astop;
            logic        ovf_now;
            token_t      t;
            p       = pos;
            off_cur = p < TEXT_LIMIT ? p : TEXT_LIMIT - 1;
            run_n   = 0;

            // apostrophe from the previous byte first
            if (held_apos)
            begin
                aoff  = p > 0 ? p - 1 : 0;
                astop = saturated ? TEXT_LIMIT : aoff;
                if (aoff > TEXT_LIMIT - 1)
                    aoff = TEXT_LIMIT - 1;
                resolve_apos(aoff, astop, is_body_byte(b));
                held_apos = 1'b0;
            end

            if (p >= TEXT_LIMIT)
                saturated = 1'b1;

            // the new byte
            if (is_blank(b))
                end_token(p);
            else if (is_mark(b))
            begin
                end_token(p);
                add_token(off_cur, 1);
            end
            else if (b == CH_APOS)
            begin
                if (last)
                    resolve_apos(off_cur, p, 1'b0);
                else
                    held_apos = 1'b1;
            end
            else if (!in_token)
            begin
                tok_start = off_cur;
                in_token  = 1'b1;
            end

            pos     = p < TEXT_LIMIT ? p + 1 : TEXT_LIMIT;
            ovf_now = saturated;

            // end of text
            if (last)
            begin
                end_token(pos);
                clear();
            end

            for (int k = 0; k < run_n; k++)
            begin
                t.off     = run_off[k][wpat_pkg::OFF_W-1:0];
                t.len     = run_len[k][wpat_pkg::LEN_W-1:0];
                t.run_end = (k == run_n - 1);
                t.done    = (k == run_n - 1) && last;
                t.ovf     = ovf_now;
                awaited   = {awaited, t};
            end
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected token: offset %0d length %0d", got.off, got.len);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.off !== want.off)
            begin
                $error("token_offset: expected %0d, got %0d", want.off, got.off);
                errors++;
            end
            if (got.len !== want.len)
            begin
                $error("token_length: expected %0d, got %0d", want.len, got.len);
                errors++;
            end
            if (got.run_end !== want.run_end)
            begin
                $error("last_of_run: expected %0d, got %0d", want.run_end, got.run_end);
                errors++;
            end
            if (got.done !== want.done)
            begin
                $error("text_done: expected %0d, got %0d", want.done, got.done);
                errors++;
            end
            if (got.ovf !== want.ovf)
            begin
                $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    token_book book = new();

    word_punct_apostrophe_tokeniser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    always #1 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_word_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (!is_body_byte(b));
        return b;
    endfunction

    // text byte with a bias towards word structure
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            b = pick_word_byte();
        else if (roll < 60)
        begin
            case ($urandom_range(0, 3))
                0:       b = CH_SPACE;
                1:       b = CH_TAB;
                2:       b = CH_LF;
                default: b = CH_CR;
            endcase
        end
        else if (roll < 75)
        begin
            case ($urandom_range(0, 5))
                0:       b = CH_DOT;
                1:       b = CH_COMMA;
                2:       b = CH_BANG;
                3:       b = CH_QUERY;
                4:       b = CH_SEMI;
                default: b = CH_COLON;
            endcase
        end
        else if (roll < 92)
            b = CH_APOS;
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // one text byte transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_texts(input int unsigned goal);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < goal)
        begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 16);
            steady = ($urandom_range(0, 6) == 0);
            for (int unsigned i = 0; i < len; i++)
                send_byte(pick_text_byte(), i == len - 1);
            sent += len;
        end
        steady = 1'b0;
    endtask

    // record accepted bytes and check tokens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                book.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                book.check_token('{ovf: m_tuser[1], done: m_tuser[0], run_end: m_tlast,
                                   len: m_tdata[32:16], off: m_tdata[15:0]});
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("word_punct_apostrophe_tokeniser: mismatch");
        $finish;
    end

    // token sink with random back-pressure
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // reset, stimulus and end of run
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // word bytes at both ends of the range, apostrophe inside a word
        send_byte(8'h00, 1'b0);
        send_byte(CH_APOS, 1'b0);
        send_byte(8'hFF, 1'b0);
        // apostrophe after a word, then whitespace
        send_byte(CH_APOS, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        // apostrophe opening a word, then punctuation
        send_byte(CH_APOS, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        // two apostrophes between boundaries
        send_byte(CH_APOS, 1'b0);
        send_byte(CH_APOS, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_DOT, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_BANG, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_QUERY, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_COLON, 1'b0);
        // apostrophe after a word as the final byte
        send_byte(8'h7A, 1'b0);
        send_byte(CH_APOS, 1'b1);
        // final byte with no token
        send_byte(CH_SPACE, 1'b1);
        // one-byte texts
        send_byte(8'h80, 1'b1);
        send_byte(CH_APOS, 1'b1);
        // word with an inner apostrophe closed by end of text
        send_byte(8'h41, 1'b0);
        send_byte(CH_APOS, 1'b0);
        send_byte(8'h42, 1'b1);

        send_random_texts(220);
        send_random_texts(20);
        s_tvalid <= 1'b0;
        @(posedge clk);

        // drain
        while (book.awaited.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (book.errors == 0 && book.awaited.size() == 0)
            $display("word_punct_apostrophe_tokeniser: match");
        else
            $display("word_punct_apostrophe_tokeniser: mismatch");
        $finish;
    end

endmodule
